>>> design/dropout_gap_interpolator_unit_macros.svh
// Assertion macros shared by the dropout gap interpolator RTL.
`ifndef DROPOUT_GAP_INTERPOLATOR_UNIT_MACROS_SVH
`define DROPOUT_GAP_INTERPOLATOR_UNIT_MACROS_SVH
`ifndef SYNTH
// Checks a property at every clock edge outside reset.
`define DGI_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("dgi: assertion failed");
// Checks that a property holds in the cycle after a trigger.
`define DGI_ASSERT_NEXT(lbl, trig, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error("dgi: assertion failed");
`else
`define DGI_ASSERT(lbl, prop)
`define DGI_ASSERT_NEXT(lbl, trig, prop)
`endif
`endif

>>> design/dgi_pkg.sv
// Shared widths and controller/datapath interface types for the gap interpolator.
`default_nettype none
package dgi_pkg;
	localparam int RATE_W    = 8;
	localparam int RUN_W     = 6;
	localparam int CNT_W     = RUN_W + 1;
	localparam int DIV_W     = RUN_W + 1;
	localparam int NUM_W     = RATE_W + RUN_W;
	localparam int DIV_STEPS = NUM_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	typedef struct packed {
		logic load_in;
		logic zero_load;
		logic bump_run;
		logic start_interp;
		logic step_num;
		logic div_step;
		logic put_zero;
		logic put_rep;
		logic put_final;
	} dgi_cmd_t;

	typedef struct packed {
		logic flush;
		logic rate_zero;
		logic anchor_zero;
		logic run_zero;
		logic run_full;
		logic div_last;
		logic cnt_last;
		logic left_last;
		logic out_free;
	} dgi_stat_t;
endpackage
`default_nettype wire

>>> design/dgi_datapath.sv
// Datapath: anchor and run state, numerator accumulator, serial divider, output register.
`default_nettype none
`include "dropout_gap_interpolator_unit_macros.svh"
module dgi_datapath #(
	parameter int MAX_GAP = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [dgi_pkg::RATE_W-1:0] heart_rate,
	input  wire logic                     flush,
	input  wire dgi_pkg::dgi_cmd_t        cmd,
	output dgi_pkg::dgi_stat_t            stat,
	output logic [dgi_pkg::RATE_W-1:0]    rate_out,
	output logic                          repaired,
	output logic                          unrepaired,
	output logic                          last,
	output logic                          out_valid,
	input  wire logic                     out_ready
);
	import dgi_pkg::*;

	logic [RATE_W-1:0]       rate_q;
	logic                    flush_q;
	logic [RATE_W-1:0]       anchor_q;
	logic [RUN_W-1:0]        run_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [RUN_W-1:0]        left_q;
	logic [DIV_W-1:0]        div_q;
	logic [NUM_W-1:0]        acc_q;
	logic [NUM_W-1:0]        quo_q;
	logic [RUN_W-1:0]        rem_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic                    out_valid_q;
	logic [RATE_W-1:0]       rate_out_q;
	logic                    repaired_q;
	logic                    unrepaired_q;
	logic                    last_q;

	logic signed [RATE_W:0]  diff;
	logic signed [NUM_W:0]   acc_sum;
	logic [NUM_W-1:0]        acc_next;
	logic [DIV_W-1:0]        rem_shift;
	logic [DIV_W-1:0]        rem_sub;
	logic                    rem_ge;
	logic [DIV_W-1:0]        run_inc;
	logic [DIV_W-1:0]        rem_ext;
	logic [RATE_W+DIV_W-1:0] anchor_prod;
	logic                    any_put;

	// The numerator of sample j grows by (rate - anchor) from one sample to the next.
	assign diff      = $signed({1'b0, rate_q}) - $signed({1'b0, anchor_q});
	assign acc_sum   = $signed({1'b0, acc_q}) + {{(NUM_W - RATE_W){diff[RATE_W]}}, diff};
	assign acc_next  = acc_sum[NUM_W-1:0];
	assign run_inc   = {1'b0, run_q} + DIV_W'(1);
	assign anchor_prod = anchor_q * run_inc;

	assign rem_shift = {rem_q, quo_q[NUM_W-1]};
	assign rem_ge    = (rem_shift >= div_q);
	assign rem_sub   = rem_shift - div_q;
	assign rem_ext   = {1'b0, rem_q};

	assign any_put   = cmd.put_zero | cmd.put_rep | cmd.put_final;

	assign stat.flush       = flush_q;
	assign stat.rate_zero   = (rate_q == '0);
	assign stat.anchor_zero = (anchor_q == '0);
	assign stat.run_zero    = (run_q == '0);
	assign stat.run_full    = (run_q >= RUN_W'(MAX_GAP));
	assign stat.div_last    = (dcnt_q == DCNT_W'(DIV_STEPS - 1));
	assign stat.cnt_last    = (cnt_q == CNT_W'(1));
	assign stat.left_last   = (left_q == RUN_W'(1));
	assign stat.out_free    = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q    <= '0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.zero_load) begin
				anchor_q <= '0;
				run_q    <= '0;
			end else if (cmd.bump_run) begin
				run_q <= run_inc[RUN_W-1:0];
			end else if (cmd.put_final) begin
				anchor_q <= rate_q;
				run_q    <= '0;
			end
			if (any_put) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			rate_q  <= heart_rate;
			flush_q <= flush;
		end
		if (cmd.zero_load) begin
			// A flush puts out only the held zeros; otherwise the new zero is counted in with them.
			cnt_q <= flush_q ? {1'b0, run_q} : run_inc;
		end else if (cmd.put_zero) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.start_interp) begin
			div_q  <= run_inc;
			acc_q  <= anchor_prod[NUM_W-1:0];
			left_q <= run_q;
		end else if (cmd.put_rep) begin
			left_q <= left_q - RUN_W'(1);
		end
		if (cmd.step_num) begin
			acc_q  <= acc_next;
			quo_q  <= acc_next;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q  <= {quo_q[NUM_W-2:0], rem_ge};
			rem_q  <= rem_ge ? rem_sub[RUN_W-1:0] : rem_shift[RUN_W-1:0];
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
		if (cmd.put_zero) begin
			rate_out_q   <= '0;
			repaired_q   <= 1'b0;
			unrepaired_q <= 1'b1;
			last_q       <= (cnt_q == CNT_W'(1));
		end else if (cmd.put_rep) begin
			rate_out_q   <= quo_q[RATE_W-1:0];
			repaired_q   <= 1'b1;
			unrepaired_q <= 1'b0;
			last_q       <= 1'b0;
		end else if (cmd.put_final) begin
			rate_out_q   <= rate_q;
			repaired_q   <= 1'b0;
			unrepaired_q <= 1'b0;
			last_q       <= 1'b1;
		end
	end

	assign rate_out   = rate_out_q;
	assign repaired   = repaired_q;
	assign unrepaired = unrepaired_q;
	assign last       = last_q;
	assign out_valid  = out_valid_q;

	`DGI_ASSERT(a_run_bounded, run_q <= RUN_W'(MAX_GAP))
	`DGI_ASSERT(a_run_needs_anchor, (run_q == '0) || (anchor_q != '0))
	`DGI_ASSERT(a_quotient_fits, !cmd.put_rep || (quo_q[NUM_W-1:RATE_W] == '0))
	`DGI_ASSERT_NEXT(a_rem_below_divisor, cmd.div_step, rem_ext < div_q)
endmodule
`default_nettype wire

>>> design/dgi_controller.sv
// Controller state machine: sequences decode, zero emission, interpolation and divide steps.
`default_nettype none
module dgi_controller (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire dgi_pkg::dgi_stat_t stat,
	output dgi_pkg::dgi_cmd_t      cmd
);
	import dgi_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECIDE = 7'b0000010,
		S_ZEROS  = 7'b0000100,
		S_NUMER  = 7'b0001000,
		S_DIVIDE = 7'b0010000,
		S_PUT    = 7'b0100000,
		S_FINAL  = 7'b1000000
	} dgi_state_t;

	dgi_state_t state_q;
	dgi_state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.flush) begin
					cmd.zero_load = 1'b1;
					state_d       = stat.run_zero ? S_IDLE : S_ZEROS;
				end else if (stat.rate_zero) begin
					// With no anchor the run is empty, so the zero leaves as a run of one.
					if (stat.anchor_zero || stat.run_full) begin
						cmd.zero_load = 1'b1;
						state_d       = S_ZEROS;
					end else begin
						cmd.bump_run = 1'b1;
						state_d      = S_IDLE;
					end
				end else if (!stat.run_zero) begin
					cmd.start_interp = 1'b1;
					state_d          = S_NUMER;
				end else begin
					state_d = S_FINAL;
				end
			end
			S_ZEROS: begin
				if (stat.out_free) begin
					cmd.put_zero = 1'b1;
					if (stat.cnt_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_NUMER: begin
				cmd.step_num = 1'b1;
				state_d      = S_DIVIDE;
			end
			S_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				if (stat.out_free) begin
					cmd.put_rep = 1'b1;
					state_d     = stat.left_last ? S_FINAL : S_NUMER;
				end
			end
			S_FINAL: begin
				if (stat.out_free) begin
					cmd.put_final = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

>>> design/dropout_gap_interpolator_unit.sv
// Top level of the heart-rate dropout gap interpolator.
//
//   channel | signals                                  | handshake
//   --------+------------------------------------------+---------------------
//   input   | heart_rate[7:0], flush                   | in_valid / in_ready
//   output  | rate_out[7:0], repaired, unrepaired, last| out_valid / out_ready
//
// One word is taken at a time; in_ready is high only while the controller is idle.
// Each word is accepted in idle and then decoded; a held zero then goes back to idle,
// and a plain good sample goes on to be put out.
// Zero runs leave at one word per cycle while the output is free. A good sample after
// k zeros puts out k repaired words first, each needing a 14-step restoring divider pass.
// The output register lets the next quotient be computed while a word waits to be taken.
// Reset clears the anchor, the zero run and the output valid bit; no clearing pass.
`default_nettype none
module dropout_gap_interpolator_unit #(
	parameter int MAX_GAP = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] heart_rate,
	input  wire logic       flush,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic [7:0]      rate_out,
	output logic            repaired,
	output logic            unrepaired,
	output logic            last,
	output logic            out_valid,
	input  wire logic       out_ready
);
	import dgi_pkg::*;

	dgi_cmd_t  cmd;
	dgi_stat_t stat;

	dgi_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dgi_datapath #(
		.MAX_GAP (MAX_GAP)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.heart_rate (heart_rate),
		.flush      (flush),
		.cmd        (cmd),
		.stat       (stat),
		.rate_out   (rate_out),
		.repaired   (repaired),
		.unrepaired (unrepaired),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);
endmodule
`default_nettype wire
